// ===== rtl/core/sba_pkg.sv =====
// Shared types and constants of the size class bitmap allocator.
`default_nettype none
package sba_pkg;

  localparam int HW_CLASSES = 3;
  localparam int SLOT_W     = 17;
  localparam int REGION_W   = 21;
  localparam int ADDR_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_SLOT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_SLOT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_SLOT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_BASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_BASE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_BASE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BYTES = 3'd6;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_NOWHERE   = 2'd3;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] request_size;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] slot_address;
    logic [1:0]        size_class;
  } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/size_class_bitmap_allocator.sv =====
// Size class bitmap allocator top level.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_stall    in_data  (req_t)
//   out      out  out_valid/out_stall  out_data (rsp_t)
//   cfg      in   cfg_write            cfg_index, cfg_data
//
// Every item that matches a class first runs the shared 32-step divider
// (region bytes / slot size); a free runs it a second time
// (offset / slot size). Allocate then reads and checks one bitmap word
// at a time until a free bit is found, then does a multiply and an add.
// After reset the bitmap RAM is swept to zero, one word a cycle, over all
// min(CLASS_COUNT, 3)*MAX_SLOTS/32 words with in_stall high.
// A finished result waits in the output register; the next item is taken
// meanwhile and only its final transfer waits on out_stall.
`default_nettype none
module size_class_bitmap_allocator
  import sba_pkg::*;
#(
  parameter int MAX_SLOTS   = 1024,
  parameter int CLASS_COUNT = 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire req_t                  in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output rsp_t                       out_data,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NCLS  = (CLASS_COUNT < HW_CLASSES) ? CLASS_COUNT : HW_CLASSES;
  localparam int WORDS = MAX_SLOTS / 32;
  localparam int DEPTH = NCLS * WORDS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int WW    = $clog2(WORDS + 1);
  localparam int IW    = $clog2(MAX_SLOTS);
  localparam int PW    = IW + SLOT_W;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DIVN  = 9'b000000100,
    S_DIVQ  = 9'b000001000,
    S_READ  = 9'b000010000,
    S_CHECK = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_ADD   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  // Configuration registers
  logic [SLOT_W-1:0]   slot_bytes [HW_CLASSES];
  logic [ADDR_W-1:0]   region_base [HW_CLASSES];
  logic [REGION_W-1:0] region_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_bytes[0]  <= SLOT_W'(16);
      slot_bytes[1]  <= SLOT_W'(64);
      slot_bytes[2]  <= SLOT_W'(256);
      region_base[0] <= 32'd0;
      region_base[1] <= 32'd16384;
      region_base[2] <= 32'd32768;
      region_bytes   <= REGION_W'(16384);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SMALL_SLOT:   slot_bytes[0]  <= cfg_data[SLOT_W-1:0];
        REG_MEDIUM_SLOT:  slot_bytes[1]  <= cfg_data[SLOT_W-1:0];
        REG_BIG_SLOT:     slot_bytes[2]  <= cfg_data[SLOT_W-1:0];
        REG_SMALL_BASE:   region_base[0] <= cfg_data;
        REG_MEDIUM_BASE:  region_base[1] <= cfg_data;
        REG_BIG_BASE:     region_base[2] <= cfg_data;
        REG_REGION_BYTES: region_bytes   <= cfg_data[REGION_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [SLOT_W-1:0] eff_slot(input logic [SLOT_W-1:0] s);
    eff_slot = (s == '0) ? SLOT_W'(1) : s;
  endfunction

  function automatic logic [AW-1:0] class_base(input logic [1:0] c);
    class_base = AW'(AW'(c) * AW'(WORDS));
  endfunction

  // Item registers
  logic              op;
  logic [1:0]        cls;
  logic [ADDR_W-1:0] offset;
  logic [WW-1:0]     nw;
  logic [WW-1:0]     w;
  logic [AW-1:0]     word_addr;
  logic [4:0]        bitpos;
  logic [IW-1:0]     slot_idx;
  logic [PW-1:0]     prod;
  rsp_t              res;
  logic [AW-1:0]     clr_addr;

  // Class selection at accept time, lowest class wins
  logic              sel_found;
  logic [1:0]        sel_cls;
  logic [ADDR_W-1:0] sel_off;
  logic [ADDR_W-1:0] off_c;

  always_comb begin
    sel_found = 1'b0;
    sel_cls   = '0;
    sel_off   = '0;
    off_c     = '0;
    for (int c = NCLS - 1; c >= 0; c--) begin
      if (in_data.operation == OP_ALLOC) begin
        if (in_data.request_size <= ADDR_W'(eff_slot(slot_bytes[c]))) begin
          sel_found = 1'b1;
          sel_cls   = 2'(c);
        end
      end else begin
        off_c = in_data.free_address - region_base[c];
        if (off_c < ADDR_W'(region_bytes)) begin
          sel_found = 1'b1;
          sel_cls   = 2'(c);
          sel_off   = off_c;
        end
      end
    end
  end

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  // Shared divider
  logic              div_start;
  logic              div_done;
  logic [ADDR_W-1:0] div_dividend;
  logic [SLOT_W-1:0] div_divisor;
  logic [ADDR_W-1:0] quotient;

  assign div_start    = (accept && sel_found) ||
                        (state == S_DIVN && div_done && op == OP_FREE);
  assign div_dividend = accept ? ADDR_W'(region_bytes) : offset;
  assign div_divisor  = accept ? eff_slot(slot_bytes[sel_cls]) : eff_slot(slot_bytes[cls]);

  sba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Usable word count from the slot count
  logic [ADDR_W-1:0] slots;
  logic [WW-1:0]     nw_calc;
  assign slots   = (quotient > ADDR_W'(MAX_SLOTS)) ? ADDR_W'(MAX_SLOTS) : quotient;
  assign nw_calc = WW'(slots >> 5);

  // Bitmap memory
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [31:0]   rdata;
  logic [31:0]   set_data;
  logic [4:0]    free_bit;

  always_comb begin
    free_bit = '0;
    for (int b = 31; b >= 0; b--) begin
      if (!rdata[b]) begin
        free_bit = 5'(b);
      end
    end
  end

  assign set_data = rdata | (32'd1 << free_bit);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = word_addr;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
    end else if (state == S_CHECK) begin
      if (op == OP_FREE) begin
        ram_we    = 1'b1;
        ram_wdata = rdata & ~(32'd1 << bitpos);
      end else if (rdata != '1) begin
        ram_we    = 1'b1;
        ram_wdata = set_data;
      end
    end
  end

  sba_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (word_addr),
    .rdata (rdata)
  );

  // Control sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // Raise the result when done, drop it after its transfer
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= sel_found ? S_DIVN : S_DONE;
          end
        end
        S_DIVN: begin
          if (div_done) begin
            if (op == OP_FREE) begin
              state <= S_DIVQ;
            end else if (nw_calc == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_DIVQ: begin
          if (div_done) begin
            state <= (quotient < ADDR_W'({nw, 5'd0})) ? S_READ : S_DONE;
          end
        end
        S_READ:  state <= S_CHECK;
        S_CHECK: begin
          if (op == OP_FREE) begin
            state <= S_DONE;
          end else if (rdata != '1) begin
            state <= S_MUL;
          end else if (w + WW'(1) == nw) begin
            state <= S_DONE;
          end else begin
            state <= S_READ;
          end
        end
        S_MUL: state <= S_ADD;
        S_ADD: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op               <= in_data.operation;
        cls              <= sel_cls;
        offset           <= sel_off;
        res.slot_address <= '0;
        res.size_class   <= sel_found ? sel_cls : 2'd0;
        res.status       <= sel_found ? ST_OK :
                            (in_data.operation == OP_ALLOC) ? ST_TOO_LARGE : ST_NOWHERE;
      end
      S_DIVN: begin
        if (div_done) begin
          nw        <= nw_calc;
          w         <= '0;
          word_addr <= class_base(cls);
          if (op == OP_ALLOC && nw_calc == '0) begin
            res.status <= ST_FULL;
          end
        end
      end
      S_DIVQ: begin
        if (div_done) begin
          word_addr <= class_base(cls) + AW'(quotient[5 +: WIW]);
          bitpos    <= quotient[4:0];
        end
      end
      S_CHECK: begin
        if (op == OP_ALLOC) begin
          if (rdata != '1) begin
            slot_idx <= IW'({w[WIW-1:0], free_bit});
          end else begin
            w         <= w + WW'(1);
            word_addr <= word_addr + AW'(1);
            if (w + WW'(1) == nw) begin
              res.status <= ST_FULL;
            end
          end
        end
      end
      S_MUL: prod <= PW'(slot_idx) * PW'(eff_slot(slot_bytes[cls]));
      S_ADD: res.slot_address <= region_base[cls] + 32'(prod);
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_data <= res;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // A bitmap word is checked only right after it was read
  a_check_after_read: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> $past(state) == S_READ)
    else $error("bitmap check without a preceding read");

  // The divider finishes only while the sequencer waits on it
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVN || state == S_DIVQ))
    else $error("divider finished outside a divide state");

  // Reset always starts the clearing sweep
  a_reset_clears: assert property (@(posedge clk)
    rst |=> state == S_CLEAR)
    else $error("reset did not start the clearing sweep");

  // The address add is always followed by a successful allocate result
  a_add_to_done: assert property (@(posedge clk) disable iff (rst)
    state == S_ADD |=> state == S_DONE && res.status == ST_OK)
    else $error("address add not followed by an ok result");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/sba_ram.sv =====
// Generic single write, single read RAM with registered read data.
`default_nettype none
module sba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 96
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/sba_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module sba_div
  import sba_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [ADDR_W-1:0] dividend,
  input  wire logic [SLOT_W-1:0] divisor,
  output logic                   done,
  output logic      [ADDR_W-1:0] quotient
);

  logic              busy;
  logic [4:0]        count;
  logic [SLOT_W-1:0] rem;
  logic [SLOT_W-1:0] dvs;
  logic [SLOT_W:0]   trial;
  logic              fits;

  assign trial = {rem, quotient[ADDR_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  // Control: run 32 steps after start
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 5'd1;
        if (count == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift, compare, subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? SLOT_W'(trial - {1'b0, dvs}) : trial[SLOT_W-1:0];
      quotient <= {quotient[ADDR_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_size_class_bitmap_allocator.sv =====
// Self-checking testbench for the size class bitmap allocator.
`default_nettype none
module tb_size_class_bitmap_allocator;
  import sba_pkg::*;

  localparam int MAX_SLOTS  = 1024;
  localparam int WORDS      = MAX_SLOTS / 32;
  localparam int LIMIT      = 2000000;
  localparam int PHASE_ITEMS = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  size_class_bitmap_allocator u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the allocator state
  logic [31:0] slot_cfg [3];
  logic [31:0] base_cfg [3];
  logic [31:0] region_len;
  logic [31:0] occupancy [3][WORDS];

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  int send_gap = 0;
  int recv_gap = 0;

  function automatic logic [31:0] eff_slot(int c);
    return (slot_cfg[c] == 0) ? 32'd1 : slot_cfg[c];
  endfunction

  function automatic int tracked_words(int c);
    logic [31:0] n;
    n = region_len / eff_slot(c);
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    return int'(n / 32);
  endfunction

  // Gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  function automatic logic [31:0] pick_size();
    int k;
    int c;
    k = $urandom_range(0, 9);
    c = $urandom_range(0, 2);
    case (k)
      0: return 32'd0;
      1: return eff_slot(c);
      2: return eff_slot(c) + 32'd1;
      3: return $urandom();
      default: return 32'($urandom_range(1, 300));
    endcase
  endfunction

  // Apply one request to the shadow state and return its response
  function automatic rsp_t allocate_or_free(req_t r);
    rsp_t p;
    int c;
    int nw;
    int b;
    logic [31:0] off;
    logic [31:0] idx;
    logic [63:0] prod;
    p = '0;
    c = 0;
    if (r.operation == OP_ALLOC) begin
      while (c < 3 && r.request_size > eff_slot(c)) c++;
      if (c == 3) begin
        p.status = ST_TOO_LARGE;
      end else begin
        nw = tracked_words(c);
        p.size_class = 2'(c);
        p.status = ST_FULL;
        for (int w = 0; w < nw; w++) begin
          if (occupancy[c][w] != 32'hFFFF_FFFF) begin
            b = 0;
            while (b < 31 && occupancy[c][w][b]) b++;
            occupancy[c][w][b] = 1'b1;
            prod = 64'(w * 32 + b) * 64'(eff_slot(c));
            p.slot_address = base_cfg[c] + prod[31:0];
            p.status = ST_OK;
            break;
          end
        end
      end
    end else begin
      off = '0;
      while (c < 3) begin
        off = r.free_address - base_cfg[c];
        if (off < region_len) break;
        c++;
      end
      if (c == 3) begin
        p.status = ST_NOWHERE;
      end else begin
        p.size_class = 2'(c);
        idx = off / eff_slot(c);
        if (idx < tracked_words(c) * 32)
          occupancy[c][idx / 32][idx % 32] = 1'b0;
      end
    end
    return p;
  endfunction

  // Queue a batch of requests aimed at the current regions
  task automatic gen_items(int n);
    req_t r;
    int k;
    int c;
    for (int i = 0; i < n; i++) begin
      r = '0;
      k = $urandom_range(0, 99);
      c = $urandom_range(0, 2);
      r.request_size = $urandom();
      r.free_address = $urandom();
      if (k < 55) begin
        r.operation = OP_ALLOC;
        r.request_size = pick_size();
      end else begin
        r.operation = OP_FREE;
        if (k < 85)
          r.free_address = base_cfg[c] + 32'($urandom_range(0, 80)) * eff_slot(c);
        else if (k < 95)
          r.free_address = base_cfg[c] + 32'($urandom_range(0, region_len + 64));
      end
      pending_reqs.push_back(r);
    end
  endtask

  // Wait until nothing is queued, offered or in flight
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0 || out_valid);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_SMALL_SLOT:   slot_cfg[0] = {15'd0, val[16:0]};
      REG_MEDIUM_SLOT:  slot_cfg[1] = {15'd0, val[16:0]};
      REG_BIG_SLOT:     slot_cfg[2] = {15'd0, val[16:0]};
      REG_SMALL_BASE:   base_cfg[0] = val;
      REG_MEDIUM_BASE:  base_cfg[1] = val;
      REG_BIG_BASE:     base_cfg[2] = val;
      REG_REGION_BYTES: region_len  = {11'd0, val[20:0]};
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Drive requests from the pending queue, predicting on each transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_rsps.push_back(allocate_or_free(in_data));
      end
      if (in_valid && in_stall) begin
        // hold the stalled payload
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_reqs.pop_front();
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Hold off the receiver for long stretches at fixed points
  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end else if (cycles == 3000 || cycles == 30000) begin
      hold_off <= 400;
    end
  end

  // Check responses and randomize back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected response", 32'(out_data.status), 32'h0);
        end else begin
          if (out_data.status != expected_rsps[0].status)
            report_mismatch("status", 32'(out_data.status), 32'(expected_rsps[0].status));
          if (out_data.slot_address != expected_rsps[0].slot_address)
            report_mismatch("slot_address", out_data.slot_address,
                            expected_rsps[0].slot_address);
          if (out_data.size_class != expected_rsps[0].size_class)
            report_mismatch("size_class", 32'(out_data.size_class),
                            32'(expected_rsps[0].size_class));
          void'(expected_rsps.pop_front());
        end
      end
      if (hold_off > 0) begin
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        out_stall <= 1'b1;
        recv_gap  <= recv_gap - 1;
      end else begin
        out_stall <= 1'b0;
        recv_gap  <= pick_gap();
      end
    end
  end

  // Reset, then three batches under different register settings
  initial begin
    slot_cfg[0] = 32'd16;
    slot_cfg[1] = 32'd64;
    slot_cfg[2] = 32'd256;
    base_cfg[0] = 32'd0;
    base_cfg[1] = 32'd16384;
    base_cfg[2] = 32'd32768;
    region_len  = 32'd16384;
    for (int c = 0; c < 3; c++)
      for (int w = 0; w < WORDS; w++)
        occupancy[c][w] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    gen_items(PHASE_ITEMS);
    wait_drained();

    // Small class of two words at the top of the address space, zero slot size
    write_cfg(REG_SMALL_SLOT, 32'd16);
    write_cfg(REG_MEDIUM_SLOT, 32'd0);
    write_cfg(REG_BIG_SLOT, 32'd4000);
    write_cfg(REG_SMALL_BASE, 32'hFFFF_FF00);
    write_cfg(REG_MEDIUM_BASE, 32'h0000_0100);
    write_cfg(REG_BIG_BASE, 32'h0000_0200);
    write_cfg(REG_REGION_BYTES, 32'd1024);
    gen_items(PHASE_ITEMS);
    wait_drained();

    // Odd slot sizes, capped slot count, random bases
    write_cfg(REG_SMALL_SLOT, 32'd7);
    write_cfg(REG_MEDIUM_SLOT, 32'd300);
    write_cfg(REG_BIG_SLOT, 32'd65536);
    write_cfg(REG_SMALL_BASE, $urandom());
    write_cfg(REG_MEDIUM_BASE, $urandom());
    write_cfg(REG_BIG_BASE, $urandom());
    write_cfg(REG_REGION_BYTES, 32'd200000);
    gen_items(PHASE_ITEMS);
    wait_drained();

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end
endmodule
`default_nettype wire
